/* design/bra_pkg.sv */
// ----------------------------------------------------------------------------
// Bitmap run allocator package
// Shared constants, the sequencer state type and the bitmap memory controls.
// ----------------------------------------------------------------------------
package bra_pkg;

   localparam int DEFAULT_SLOTS = 1024;
   localparam int WORD_BITS     = 64;
   localparam int BIT_W         = 6;
   localparam int IDX_W         = 10;
   localparam int LEN_W         = 11;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FREE_RD,
      ST_FREE_WR,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_GROW_RD,
      ST_GROW_EV,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctrl_type;

endpackage

/* design/bra_bitmap_mem.sv */
// ----------------------------------------------------------------------------
// Bitmap word memory
// One word of occupancy bits per entry, one shared address, registered read.
// ----------------------------------------------------------------------------
module bra_bitmap_mem import bra_pkg::*; #(
   parameter int WORDS = 16,
   parameter int WW    = 4
) (
   input  logic                 clock,
   input  mem_ctrl_type         ctrl,
   input  logic [WW-1:0]        addr,
   input  logic [WORD_BITS-1:0] wr_data,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mem [WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/bra_bit_scan.sv */
// ----------------------------------------------------------------------------
// Bit scan unit
// Finds the lowest set bit of a word at or above a start position.
// ----------------------------------------------------------------------------
module bra_bit_scan import bra_pkg::*; (
   input  logic [WORD_BITS-1:0] word_data,
   input  logic [BIT_W-1:0]     start,
   output logic                 hit,
   output logic [BIT_W-1:0]     pos
);

   logic [WORD_BITS-1:0] masked;

   always_comb begin
      masked = word_data & ({WORD_BITS{1'b1}} << start);
      hit    = |masked;
      pos    = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (masked[i]) begin
            pos = BIT_W'(i);
         end
      end
   end

endmodule

/* design/bitmap_run_allocator_core.sv */
// ----------------------------------------------------------------------------
// Bitmap run allocator core
// First-fit run allocator over an occupancy bitmap held in word memory.
// ----------------------------------------------------------------------------
// The bitmap lives in a memory of 64-slot words with a single port, and one
// item is handled at a time. After reset a clearing pass writes ceil(SLOTS/64)
// words, one a cycle, before the first item is taken. A free item reads its
// word and then writes it back with the slot's bit cleared. An allocate item
// reads and then evaluates every bitmap word it visits, first while looking
// for a free slot and then while growing the run, and then hands over the
// result. Each word read is evaluated by one shared bit scan unit.
module bitmap_run_allocator_core import bra_pkg::*; #(
   parameter int SLOTS = DEFAULT_SLOTS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_op,
   input  logic [IDX_W-1:0] req_slot_index,
   input  logic [LEN_W-1:0] req_run_length,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [IDX_W-1:0] rsp_first_slot,
   output logic [IDX_W-1:0] rsp_last_slot,
   output logic             rsp_found
);

   localparam int WORDS     = (SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int WW        = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int PW        = WW + BIT_W;
   localparam int SUMW      = ((PW > LEN_W) ? PW : LEN_W) + 1;
   localparam int CMPW      = ((PW > IDX_W) ? PW : IDX_W) + 1;
   localparam int XW        = (PW > IDX_W) ? PW : IDX_W;
   localparam int TAIL_BITS = SLOTS - WORD_BITS * (WORDS - 1);
   localparam logic [WORD_BITS-1:0] TAIL_MASK =
      ~({WORD_BITS{1'b1}} >> (WORD_BITS - TAIL_BITS));

   state_type            state_ff, state_in;
   logic [WW-1:0]        word_ff, word_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   logic [PW-1:0]        first_ff, first_in;
   logic [PW-1:0]        last_ff, last_in;
   logic [PW-1:0]        limit_ff, limit_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [IDX_W-1:0]     res_first_ff, res_first_in;
   logic [IDX_W-1:0]     res_last_ff, res_last_in;
   logic                 res_found_ff, res_found_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]     rsp_first_ff, rsp_first_in;
   logic [IDX_W-1:0]     rsp_last_ff, rsp_last_in;
   logic                 rsp_found_ff, rsp_found_in;

   mem_ctrl_type         mem_ctrl;
   logic [WORD_BITS-1:0] wr_data;
   logic [WORD_BITS-1:0] rd_data;
   logic [WORD_BITS-1:0] occ_word;
   logic [WORD_BITS-1:0] scan_word;
   logic                 scan_hit;
   logic [BIT_W-1:0]     scan_pos;

   logic [CMPW-1:0]      idx_ext;
   logic                 idx_in_range;
   logic                 last_word;
   logic [PW-1:0]        found_slot;
   logic [SUMW-1:0]      run_sum;
   logic [BIT_W-1:0]     occ_end;
   logic [BIT_W-1:0]     lim_end;
   logic [BIT_W-1:0]     run_end;
   logic                 lim_here;
   logic                 occ_stop;
   logic [PW-1:0]        run_last;
   logic [XW-1:0]        first_x;
   logic [XW-1:0]        last_x;
   logic                 rsp_load;

   bra_bitmap_mem #(
      .WORDS (WORDS),
      .WW    (WW)
   ) u_mem (
      .clock   (clock),
      .ctrl    (mem_ctrl),
      .addr    (word_ff),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   bra_bit_scan u_scan (
      .word_data (scan_word),
      .start     (bit_ff),
      .hit       (scan_hit),
      .pos       (scan_pos)
   );

   // Slots past the end of the bitmap read as occupied.
   assign last_word = (word_ff == WW'(WORDS - 1));
   assign occ_word  = rd_data | (last_word ? TAIL_MASK : '0);
   assign scan_word = (state_ff == ST_SCAN_EV) ? ~occ_word : occ_word;

   assign idx_ext      = CMPW'(req_slot_index);
   assign idx_in_range = (idx_ext < CMPW'(SLOTS));
   assign found_slot   = {word_ff, scan_pos};
   assign run_sum      = SUMW'(found_slot) + SUMW'(len_ff) - SUMW'(1);

   assign lim_here = (limit_ff[PW-1:BIT_W] == word_ff);
   assign lim_end  = lim_here ? limit_ff[BIT_W-1:0] : {BIT_W{1'b1}};
   assign occ_end  = scan_hit ? (scan_pos - BIT_W'(1)) : {BIT_W{1'b1}};
   assign run_end  = (occ_end < lim_end) ? occ_end : lim_end;
   assign occ_stop = scan_hit && (scan_pos == bit_ff);
   assign run_last = {word_ff, run_end};

   assign rsp_load = (state_ff == ST_RESP) && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         word_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bit_ff       <= bit_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
      limit_ff     <= limit_in;
      len_ff       <= len_in;
      res_first_ff <= res_first_in;
      res_last_ff  <= res_last_in;
      res_found_ff <= res_found_in;
      rsp_first_ff <= rsp_first_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_found_ff <= rsp_found_in;
   end

   always_comb begin
      state_in     = state_ff;
      word_in      = word_ff;
      bit_in       = bit_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      limit_in     = limit_ff;
      len_in       = len_ff;
      res_first_in = res_first_ff;
      res_last_in  = res_last_ff;
      res_found_in = res_found_ff;
      mem_ctrl     = '0;
      wr_data      = '0;
      first_x      = XW'(first_ff);
      last_x       = XW'(last_ff);
      req_stall    = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_CLEAR: begin
            mem_ctrl.wr_en = 1'b1;
            word_in        = word_ff + WW'(1);
            if (last_word) begin
               word_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               word_in = WW'(idx_ext >> BIT_W);
               bit_in  = idx_ext[BIT_W-1:0];
               len_in  = (req_run_length == '0) ? LEN_W'(1) : req_run_length;
               if (req_op == OP_FREE) begin
                  if (idx_in_range) begin
                     state_in = ST_FREE_RD;
                  end
               end else if (idx_in_range) begin
                  state_in = ST_SCAN_RD;
               end else begin
                  res_first_in = '0;
                  res_last_in  = '0;
                  res_found_in = 1'b0;
                  state_in     = ST_RESP;
               end
            end
         end
         ST_FREE_RD: begin
            mem_ctrl.rd_en = 1'b1;
            state_in       = ST_FREE_WR;
         end
         ST_FREE_WR: begin
            mem_ctrl.wr_en = 1'b1;
            wr_data        = rd_data & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << bit_ff);
            state_in       = ST_IDLE;
         end
         ST_SCAN_RD: begin
            mem_ctrl.rd_en = 1'b1;
            state_in       = ST_SCAN_EV;
         end
         ST_SCAN_EV: begin
            if (scan_hit) begin
               first_in = found_slot;
               last_in  = found_slot;
               bit_in   = scan_pos;
               limit_in = (run_sum > SUMW'(SLOTS - 1)) ? PW'(SLOTS - 1) : run_sum[PW-1:0];
               state_in = ST_GROW_EV;
            end else if (last_word) begin
               res_first_in = '0;
               res_last_in  = '0;
               res_found_in = 1'b0;
               state_in     = ST_RESP;
            end else begin
               word_in  = word_ff + WW'(1);
               bit_in   = '0;
               state_in = ST_SCAN_RD;
            end
         end
         ST_GROW_RD: begin
            mem_ctrl.rd_en = 1'b1;
            state_in       = ST_GROW_EV;
         end
         ST_GROW_EV: begin
            if (occ_stop) begin
               res_first_in = first_x[IDX_W-1:0];
               res_last_in  = last_x[IDX_W-1:0];
               res_found_in = 1'b1;
               state_in     = ST_RESP;
            end else begin
               mem_ctrl.wr_en = 1'b1;
               wr_data        = rd_data | (({WORD_BITS{1'b1}} << bit_ff)
                                & ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - run_end)));
               last_in        = run_last;
               if (!scan_hit && !lim_here) begin
                  word_in  = word_ff + WW'(1);
                  bit_in   = '0;
                  state_in = ST_GROW_RD;
               end else begin
                  last_x       = XW'(run_last);
                  res_first_in = first_x[IDX_W-1:0];
                  res_last_in  = last_x[IDX_W-1:0];
                  res_found_in = 1'b1;
                  state_in     = ST_RESP;
               end
            end
         end
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_first_in = rsp_first_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_found_in = rsp_found_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_first_in = res_first_ff;
         rsp_last_in  = res_last_ff;
         rsp_found_in = res_found_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_first_slot = rsp_first_ff;
   assign rsp_last_slot  = rsp_last_ff;
   assign rsp_found      = rsp_found_ff;

   // A new result only appears after the sequencer has reached its hand-over state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RESP)
      else $error("result shown without a finished item");

   // A found free slot always starts the run in the word just read.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_EV && scan_hit) |=> (state_ff == ST_GROW_EV && bit_ff == $past(scan_pos)))
      else $error("run growth did not start at the found slot");

   // The run limit never lies before the run's first slot.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GROW_EV || state_ff == ST_GROW_RD) |-> limit_ff >= first_ff)
      else $error("run limit below the first slot");

   // The memory is never read and written in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      !(mem_ctrl.rd_en && mem_ctrl.wr_en))
      else $error("bitmap read and write collide");

endmodule

/* dv/bra_alloc_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bitmap run allocator checker
// Watches both channels of the allocator core, keeps its own occupancy bitmap,
// predicts the run that each accepted allocate item should claim, and compares
// every accepted result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module bra_alloc_checker import bra_pkg::*; #(
   parameter int SLOTS = DEFAULT_SLOTS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  logic             req_op,
   input  logic [IDX_W-1:0] req_slot_index,
   input  logic [LEN_W-1:0] req_run_length,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  logic [IDX_W-1:0] rsp_first_slot,
   input  logic [IDX_W-1:0] rsp_last_slot,
   input  logic             rsp_found,
   output int               fail_count,
   output int               pending_runs
);

   typedef struct packed {
      logic [IDX_W-1:0] first_slot;
      logic [IDX_W-1:0] last_slot;
      logic             found;
   } run_result_type;

   bit             occupied [SLOTS];
   run_result_type expected_runs [$];
   run_result_type oldest_run;

   initial begin
      fail_count   = 0;
      pending_runs = 0;
   end

   function automatic run_result_type allocate_run(input logic [IDX_W-1:0] start,
                                                   input logic [LEN_W-1:0] wanted);
      run_result_type result;
      int             first;
      int             limit;
      int             last;
      int             run_len;
      result  = '0;
      run_len = (wanted == 0) ? 1 : int'(wanted);
      first   = SLOTS;
      for (int i = int'(start); i < SLOTS; i++) begin
         if (!occupied[i]) begin
            first = i;
            break;
         end
      end
      if (first >= SLOTS) begin
         return result;
      end
      limit = first + run_len - 1;
      if (limit > SLOTS - 1) begin
         limit = SLOTS - 1;
      end
      last = first;
      occupied[first] = 1'b1;
      while (last < limit && !occupied[last + 1]) begin
         last++;
         occupied[last] = 1'b1;
      end
      result.first_slot = first[IDX_W-1:0];
      result.last_slot  = last[IDX_W-1:0];
      result.found      = 1'b1;
      return result;
   endfunction

   task automatic check_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (occupied[i]) begin
            occupied[i] = 1'b0;
         end
         expected_runs.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_runs.size() == 0) begin
               $error("result item with no allocate outstanding: first_slot %0d",
                      rsp_first_slot);
               fail_count++;
            end else begin
               oldest_run = expected_runs.pop_front();
               check_field("first_slot", oldest_run.first_slot, rsp_first_slot);
               check_field("last_slot", oldest_run.last_slot, rsp_last_slot);
               check_field("found", oldest_run.found, rsp_found);
            end
         end
         if (req_valid && !req_stall) begin
            if (req_op == OP_FREE) begin
               if (int'(req_slot_index) < SLOTS) begin
                  occupied[req_slot_index] = 1'b0;
               end
            end else begin
               expected_runs.push_back(allocate_run(req_slot_index, req_run_length));
            end
         end
      end
      pending_runs = expected_runs.size();
   end

endmodule

/* dv/tb_bitmap_run_allocator_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bitmap run allocator core testbench
// Drives directed corner cases and then random allocate and free traffic,
// including bursts of consecutive frees, through four phases that vary sender
// gaps and receiver stalls. The checker beside the core judges every result.
// ----------------------------------------------------------------------------
module tb_bitmap_run_allocator_core;
   import bra_pkg::*;

   localparam int SLOTS = DEFAULT_SLOTS;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic             req_op;
   logic [IDX_W-1:0] req_slot_index;
   logic [LEN_W-1:0] req_run_length;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [IDX_W-1:0] rsp_first_slot;
   logic [IDX_W-1:0] rsp_last_slot;
   logic             rsp_found;
   int               fail_count;
   int               pending_runs;
   int               idle_pct;
   int               stall_pct;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bitmap_run_allocator_core #(.SLOTS(SLOTS)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_slot_index (req_slot_index),
      .req_run_length (req_run_length),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_first_slot (rsp_first_slot),
      .rsp_last_slot  (rsp_last_slot),
      .rsp_found      (rsp_found)
   );

   bra_alloc_checker #(.SLOTS(SLOTS)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_slot_index (req_slot_index),
      .req_run_length (req_run_length),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_first_slot (rsp_first_slot),
      .rsp_last_slot  (rsp_last_slot),
      .rsp_found      (rsp_found),
      .fail_count     (fail_count),
      .pending_runs   (pending_runs)
   );

   initial begin
      rsp_stall = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall = !reset && ($urandom_range(99) < stall_pct);
   end

   task automatic send_item(input logic op, input logic [IDX_W-1:0] slot,
                            input logic [LEN_W-1:0] run_len);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid      = 1'b1;
      req_op         = op;
      req_slot_index = slot;
      req_run_length = run_len;
      do begin
         @(posedge clock);
      end while (req_stall);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_runs != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      int               sent;
      int               pick;
      int               base;
      int               burst;
      logic [IDX_W-1:0] start;
      logic [LEN_W-1:0] run_len;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_op         = OP_ALLOC;
      req_slot_index = '0;
      req_run_length = 11'd1;
      idle_pct       = 0;
      stall_pct      = 0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      send_item(OP_ALLOC, 10'd0, 11'd1);
      send_item(OP_ALLOC, 10'd0, 11'd0);
      send_item(OP_ALLOC, 10'd0, 11'd1024);
      send_item(OP_ALLOC, 10'd0, 11'd5);
      send_item(OP_FREE, 10'd1023, 11'd2047);
      send_item(OP_FREE, 10'd0, 11'd0);
      send_item(OP_FREE, 10'd500, 11'd1);
      send_item(OP_FREE, 10'd500, 11'd1);
      send_item(OP_ALLOC, 10'd1023, 11'd2047);
      send_item(OP_ALLOC, 10'd0, 11'd3);
      send_item(OP_ALLOC, 10'd400, 11'd2);
      send_item(OP_ALLOC, 10'd1023, 11'd1);
      for (int k = 60; k <= 70; k++) begin
         send_item(OP_FREE, k[IDX_W-1:0], 11'd1024);
      end
      send_item(OP_ALLOC, 10'd0, 11'd2047);
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 48; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 48; end
            default: begin idle_pct = 8; stall_pct = 8; end
         endcase
         sent = 0;
         while (sent < 275) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
               base  = $urandom_range(SLOTS - 1);
               burst = $urandom_range(64, 1);
               for (int k = 0; k < burst && base + k < SLOTS; k++) begin
                  send_item(OP_FREE, IDX_W'(base + k), LEN_W'($urandom));
                  sent++;
               end
            end else if (pick < 38) begin
               send_item(OP_FREE, IDX_W'($urandom), LEN_W'($urandom));
               sent++;
            end else begin
               start = ($urandom_range(99) < 30) ? IDX_W'($urandom_range(63))
                                                 : IDX_W'($urandom);
               pick = $urandom_range(99);
               if (pick < 60) begin
                  run_len = LEN_W'($urandom_range(8, 1));
               end else if (pick < 85) begin
                  run_len = LEN_W'($urandom_range(64, 9));
               end else if (pick < 95) begin
                  run_len = LEN_W'($urandom_range(1023, 65));
               end else if (pick < 98) begin
                  run_len = LEN_W'($urandom_range(2047, 1024));
               end else begin
                  run_len = '0;
               end
               send_item(OP_ALLOC, start, run_len);
               sent++;
            end
         end
         drain_results();
      end

      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
